[sv/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants
// Sizes and the job record passed from the conversion front to the
// character back end of the binary to padded ASCII decimal block.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

  localparam int MAX_WIDTH  = 20;
  localparam int VALUE_BITS = 16;

  // Decimal digits needed for the largest value of a given bit count.
  function automatic int dec_digits(input int bits);
    longint unsigned v;
    int n;
    v = (64'd1 << bits) - 64'd1;
    n = 0;
    while (v != 0) begin
      v = v / 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int NUM_DIGITS = dec_digits(VALUE_BITS);
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int STEP_W     = $clog2(VALUE_BITS);
  localparam int WANT_MAX   = 31;
  localparam int CNT_TOP    = (MAX_WIDTH > NUM_DIGITS) ?
                              ((MAX_WIDTH > WANT_MAX) ? MAX_WIDTH : WANT_MAX) :
                              ((NUM_DIGITS > WANT_MAX) ? NUM_DIGITS : WANT_MAX);
  localparam int CNT_W      = $clog2(CNT_TOP + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    bcd_t             bcd;
    logic [CNT_W-1:0] width;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[sv/binary_to_decimal_ascii_padded_top.sv]
// Path of a command: after start is accepted come the conversion steps,
// hand-over to the queue, job load and output register before the first character.
// The front stays busy through the one-bit-a-cycle BCD loop and a hand-over
// that waits while the queue is full; the back loads a job, then sends its run.
// The front can take a new command while the back sends. Results cannot be held off.
// Reset clears all control state; no memory needs a clearing pass.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_padded_top: binary to padded ASCII decimal
// Converts an unsigned value to a zero-padded run of decimal characters,
// most significant first, with the final character flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_padded_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  wire  [b2da_pkg::VALUE_BITS-1:0]  value_i,
  input  wire  [4:0]                       min_width_i,
  output logic                             strobe_o,
  output logic [5:0]                       digit_char_o,
  output logic                             last_o
);
  import b2da_pkg::*;

  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  job_t    front_job;
  job_t    head_job;
  logic    push;
  logic    pop;

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  b2da_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .value_i     (value_i),
    .min_width_i (min_width_i),
    .busy_o      (busy),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (front_job)
  );

  b2da_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .job_i  (front_job),
    .stat_o (q_stat),
    .job_o  (head_job)
  );

  b2da_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .job_i        (head_job),
    .pop_o        (pop),
    .strobe_o     (strobe_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[sv/b2da_front.sv]
// ----------------------------------------------------------------------------
// b2da_front: command intake and binary to BCD conversion
// Accepts a value and a field width, converts the value with a shift and
// add-three loop, one bit a cycle, and sizes the character run.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire  [b2da_pkg::VALUE_BITS-1:0]  value_i,
  input  wire  [4:0]                       min_width_i,
  output logic                             busy_o,
  input  wire  b2da_pkg::q_stat_t          q_stat_i,
  output logic                             push_o,
  output b2da_pkg::job_t                   job_o
);
  import b2da_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  bcd_t                  bcd_q, bcd_d;
  logic [CNT_W-1:0]      want_q, want_d;

  bcd_t                  bcd_adj;
  logic [BCD_W-1:0]      bcd_flat;
  logic [CNT_W-1:0]      ndig;
  logic [CNT_W-1:0]      width;
  logic                  accept;

  assign busy_o = (state_q != F_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  assign bcd_flat = bcd_adj;

  // Natural digit count: one above the highest non-zero digit, at least one.
  always_comb begin
    ndig = CNT_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i] != 4'd0) begin
        ndig = CNT_W'(i + 1);
      end
    end
  end

  assign width = ((want_q == '0) || (want_q < ndig)) ? ndig : want_q;

  always_comb begin
    job_o.bcd   = bcd_q;
    job_o.width = width;
    job_o.count = (width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : width;
  end

  assign push_o = (state_q == F_PUSH) && !q_stat_i.full;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    want_d  = want_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          bin_d   = value_i;
          bcd_d   = '0;
          step_d  = '0;
          want_d  = (CNT_W'(min_width_i) > CNT_W'(MAX_WIDTH)) ?
                    CNT_W'(MAX_WIDTH) : CNT_W'(min_width_i);
          state_d = F_CONV;
        end
      end
      F_CONV: begin
        bcd_d  = {bcd_flat[BCD_W-2:0], bin_q[VALUE_BITS-1]};
        bin_d  = {bin_q[VALUE_BITS-2:0], 1'b0};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(VALUE_BITS - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    want_q <= want_d;
  end

  // A job always carries between one and MAX_WIDTH characters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (job_o.count != '0) && (job_o.count <= CNT_W'(MAX_WIDTH)))
    else $error("front: job character count out of range");

  // A completed transfer into the queue frees the front for the next command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> !busy_o)
    else $error("front: still busy after handing over a job");

endmodule

`default_nettype wire

[sv/b2da_queue.sv]
// ----------------------------------------------------------------------------
// b2da_queue: job queue between front and back
// A short register queue so that conversion and character output stall
// independently of each other.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_queue (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  b2da_pkg::q_ctrl_t ctrl_i,
  input  wire  b2da_pkg::job_t    job_i,
  output b2da_pkg::q_stat_t       stat_o,
  output b2da_pkg::job_t          job_o
);
  import b2da_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   fill_q;

  assign stat_o.full  = (fill_q == (QPTR_W + 1)'(QDEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign job_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (ctrl_i.push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (ctrl_i.pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({ctrl_i.push, ctrl_i.pop})
        2'b10:   fill_q <= fill_q + (QPTR_W + 1)'(1);
        2'b01:   fill_q <= fill_q - (QPTR_W + 1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && stat_o.full) && !(ctrl_i.pop && stat_o.empty))
    else $error("queue: transfer against full or empty queue");

endmodule

`default_nettype wire

[sv/b2da_back.sv]
// ----------------------------------------------------------------------------
// b2da_back: character sequencer
// Takes one job at a time from the queue and sends its characters, most
// significant first, one a cycle, with padding positions sent as '0'.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  b2da_pkg::q_stat_t q_stat_i,
  input  wire  b2da_pkg::job_t    job_i,
  output logic                    pop_o,
  output logic                    strobe_o,
  output logic [5:0]              digit_char_o,
  output logic                    last_o
);
  import b2da_pkg::*;

  logic             active_q, active_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] remain_q, remain_d;
  bcd_t             bcd_q, bcd_d;
  logic             strobe_q, strobe_d;
  logic [5:0]       char_q, char_d;
  logic             last_q, last_d;
  logic [3:0]       digit;

  // Positions above the top stored digit are padding.
  always_comb begin
    digit = 4'd0;
    if (pos_q < CNT_W'(NUM_DIGITS)) begin
      digit = bcd_q[pos_q[DIG_IDX_W-1:0]];
    end
  end

  always_comb begin
    active_d = active_q;
    pos_d    = pos_q;
    remain_d = remain_q;
    bcd_d    = bcd_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = 1'b0;
    pop_o    = 1'b0;
    if (!active_q) begin
      if (!q_stat_i.empty) begin
        pop_o    = 1'b1;
        active_d = 1'b1;
        bcd_d    = job_i.bcd;
        pos_d    = job_i.width - CNT_W'(1);
        remain_d = job_i.count;
      end
    end else begin
      strobe_d = 1'b1;
      char_d   = ASCII_ZERO + {2'b00, digit};
      last_d   = (remain_q == CNT_W'(1));
      pos_d    = pos_q - CNT_W'(1);
      remain_d = remain_q - CNT_W'(1);
      if (remain_q == CNT_W'(1)) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      strobe_q <= 1'b0;
      remain_q <= '0;
    end else begin
      active_q <= active_d;
      strobe_q <= strobe_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign strobe_o     = strobe_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (remain_q != '0))
    else $error("back: active with no characters left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |-> !active_q)
    else $error("back: run continues after its final character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (digit_char_o >= ASCII_ZERO) && (digit_char_o <= ASCII_ZERO + 6'd9))
    else $error("back: character outside the decimal digits");

endmodule

`default_nettype wire

[tb/sv/binary_to_decimal_ascii_padded_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_padded_top_tb: self-checking bench for the decimal
// renderer
// Commands carrying a value and a minimum width are issued through the
// start/busy handshake with random gaps. Each accepted command is rendered
// into its expected character run here. Every strobed character is checked
// against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_padded_top_tb;

  import b2da_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 4;
  localparam int RANDOM_CMDS = 360;
  localparam int STALL_LIMIT = 1000;
  localparam int DIG_SLOTS   = MAX_WIDTH + 12;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [4:0]            min_width;
    logic                  drain;
  } conv_cmd_t;

  typedef struct packed {
    logic [5:0] digit_char;
    logic       last;
  } dec_char_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic [VALUE_BITS-1:0] value_i     = '0;
  logic [4:0]            min_width_i = '0;
  logic                  busy;
  logic                  strobe_o;
  logic [5:0]            digit_char_o;
  logic                  last_o;

  conv_cmd_t cmd_q[$];
  dec_char_t char_q[$];
  conv_cmd_t next_cmd;
  int        issued_cnt  = 0;
  int        error_count = 0;
  int        stall_cnt   = 0;
  logic      quiet;

  binary_to_decimal_ascii_padded_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .min_width_i  (min_width_i),
    .strobe_o     (strobe_o),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Works out the character run for one command and appends it to char_q.
  task automatic render_decimal(input logic [VALUE_BITS-1:0] val,
                                input logic [4:0] min_w);
    logic [3:0] digs [DIG_SLOTS];
    int unsigned v;
    int unsigned want;
    int unsigned ndig;
    int unsigned width;
    int unsigned count;
    int unsigned pos;
    dec_char_t   ch;
    for (int k = 0; k < DIG_SLOTS; k++) digs[k] = 4'd0;
    v    = val;
    ndig = 0;
    do begin
      if (ndig < DIG_SLOTS) digs[ndig] = 4'(v % 10);
      v    = v / 10;
      ndig = ndig + 1;
    end while (v != 0);
    want  = (min_w > MAX_WIDTH) ? MAX_WIDTH : min_w;
    width = (want == 0 || want < ndig) ? ndig : want;
    count = (width > MAX_WIDTH) ? MAX_WIDTH : width;
    for (int unsigned k = 0; k < count; k++) begin
      pos           = width - 1 - k;
      ch.digit_char = ASCII_ZERO + ((pos < DIG_SLOTS) ? 6'(digs[pos]) : 6'd0);
      ch.last       = (k + 1 == count);
      char_q.push_back(ch);
    end
  endtask

  task automatic add_cmd(input int v, input int w, input logic drain);
    conv_cmd_t c;
    c.value     = VALUE_BITS'(v);
    c.min_width = 5'(w);
    c.drain     = drain;
    cmd_q.push_back(c);
  endtask

  // Command driver. busy and start are sampled before this edge's updates.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      value_i     <= '0;
      min_width_i <= '0;
    end else begin
      if (start && !busy) render_decimal(value_i, min_width_i);
      if (!start || !busy) begin
        // A quiet stretch in the middle of the run drops the random gaps between commands.
        quiet = (issued_cnt >= 140 && issued_cnt < 240);
        if (cmd_q.size() == 0 || (!quiet && $urandom_range(0, 99) < 11) ||
            (cmd_q[0].drain && char_q.size() != 0)) begin
          start <= 1'b0;
        end else begin
          next_cmd    = cmd_q.pop_front();
          value_i     <= next_cmd.value;
          min_width_i <= next_cmd.min_width;
          start       <= 1'b1;
          issued_cnt  = issued_cnt + 1;
        end
      end
    end
  end

  // Character monitor: the block cannot be held off, so every strobe is a transfer.
  always @(posedge clk_i) begin
    dec_char_t exp_ch;
    if (rst_ni && strobe_o) begin
      if (char_q.size() == 0) begin
        $error("unexpected character: digit_char %0d last %0b", digit_char_o, last_o);
        error_count = error_count + 1;
      end else begin
        exp_ch = char_q.pop_front();
        if (digit_char_o !== exp_ch.digit_char) begin
          $error("digit_char: expected %0d, actual %0d", exp_ch.digit_char, digit_char_o);
          error_count = error_count + 1;
        end
        if (last_o !== exp_ch.last) begin
          $error("last: expected %0b, actual %0b", exp_ch.last, last_o);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || strobe_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("binary_to_decimal_ascii_padded_top verification failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    // Extremes, padding, saturation of the width and powers of ten.
    add_cmd(0, 0, 1'b0);
    add_cmd(0, 1, 1'b0);
    add_cmd(0, 20, 1'b0);
    add_cmd(0, 31, 1'b0);
    add_cmd(65535, 0, 1'b0);
    add_cmd(65535, 4, 1'b0);
    add_cmd(65535, 5, 1'b0);
    add_cmd(65535, 6, 1'b0);
    add_cmd(65535, 21, 1'b0);
    add_cmd(1, 20, 1'b0);
    add_cmd(9, 0, 1'b0);
    add_cmd(10, 2, 1'b0);
    add_cmd(100, 1, 1'b0);
    add_cmd(1000, 19, 1'b0);
    add_cmd(10000, 31, 1'b0);
    add_cmd(12345, 0, 1'b0);
    add_cmd(16'hAAAA, 10, 1'b0);
    add_cmd(16'h5555, 21, 1'b0);
    add_cmd(40000, 30, 1'b1);
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      // Shifting spreads values over every digit count.
      add_cmd($urandom_range(0, 65535) >> $urandom_range(0, 16),
              $urandom_range(0, 31), (i % 60) == 30);
    end

    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || start || char_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (error_count == 0) begin
      $display("binary_to_decimal_ascii_padded_top verification clean");
    end else begin
      $display("binary_to_decimal_ascii_padded_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/b2da_pkg.sv
sv/b2da_front.sv
sv/b2da_queue.sv
sv/b2da_back.sv
sv/binary_to_decimal_ascii_padded_top.sv
tb/sv/binary_to_decimal_ascii_padded_top_tb.sv
